### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the erasure corrector RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RSEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define RSEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rsec_pkg.sv
// ----------------------------------------------------------------------------
// rsec_pkg
// Types, constants and GF(256) arithmetic for the erasure corrector.
// ----------------------------------------------------------------------------
package rsec_pkg;

  localparam int MAX_ERASURES      = 4;
  localparam int DATA_BLOCKS_DEF   = 85;
  localparam int LAST_POSITION_DEF = 88;
  localparam int GF_ORDER          = 255;
  localparam logic [7:0] GF_POLY_LOW = 8'h1D;
  localparam int QUEUE_DEPTH       = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS3  = 3'd4;

  typedef logic [7:0] gf_tab_t [256];
  typedef logic [3:0][3:0][7:0] coeff_t;

  typedef struct packed {
    logic [7:0] syndrome_0;
    logic [7:0] syndrome_1;
    logic [7:0] syndrome_2;
    logic [7:0] syndrome_3;
    logic [7:0] data_0;
    logic [7:0] data_1;
    logic [7:0] data_2;
    logic [7:0] data_3;
    logic       column_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] fixed_0;
    logic [7:0] fixed_1;
    logic [7:0] fixed_2;
    logic [7:0] fixed_3;
    logic [3:0] write_mask;
    logic       status;
    logic       last_out;
  } out_item_t;

  // Settings seen by the front part.
  typedef struct packed {
    logic [2:0]      count;
    logic [3:0][6:0] pos;
    logic            ok;
    logic            busy;
  } setup_t;

  // One classified column waiting in the queue.
  typedef struct packed {
    in_item_t   item;
    logic [3:0] used;
    logic [3:0] mask;
    logic       status;
  } work_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = '0;
    x = a;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) r = r ^ x;
      x = x[7] ? ({x[6:0], 1'b0} ^ GF_POLY_LOW) : {x[6:0], 1'b0};
    end
    return r;
  endfunction

  function automatic gf_tab_t gen_exp();
    gf_tab_t t;
    logic [7:0] x;
    x = 8'd1;
    for (int i = 0; i < GF_ORDER; i++) begin
      t[i] = x;
      x = gf_mul(x, 8'd2);
    end
    t[GF_ORDER] = t[0];
    return t;
  endfunction

  localparam gf_tab_t GF_EXP = gen_exp();

  function automatic gf_tab_t gen_log();
    gf_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = '0;
    for (int i = 0; i < GF_ORDER; i++) t[GF_EXP[i]] = 8'(i);
    return t;
  endfunction

  localparam gf_tab_t GF_LOG = gen_log();

  // Inverse through log and antilog; zero maps to zero.
  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] lg;
    logic [7:0] e;
    lg = GF_LOG[a];
    e  = (lg == 8'd0) ? 8'd0 : 8'(GF_ORDER) - lg;
    return (a == 8'd0) ? 8'd0 : GF_EXP[e];
  endfunction

endpackage

### rtl/rsec_stream_if.sv
// ----------------------------------------------------------------------------
// rsec_stream_if
// Valid/ready channel carrying one word of payload type T.
// ----------------------------------------------------------------------------
interface rsec_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/rs_erasure_corrector_gf256.sv
// ----------------------------------------------------------------------------
// rs_erasure_corrector_gf256
// Reed-Solomon erasure corrector over GF(256), up to four erased blocks.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// in_chan   sink       four syndrome bytes, four erased bytes, last flag
// out_chan  source     four corrected bytes, write mask, status, last flag
// cfg_*     write      erasure count and four erasure positions
//
// One column is accepted per cycle while in_chan.ready is high; its result passes
// through a two-word queue and then the output register.
// After each configuration write the matrix sequencer computes the locators,
// then each row in turn; in_chan.ready is low meanwhile.
// Reset is synchronous: count and positions zero, matrix zero.
// A stalled output holds its word; the queue keeps taking columns until full.
// ----------------------------------------------------------------------------
module rs_erasure_corrector_gf256 #(
  parameter int DATA_BLOCKS   = rsec_pkg::DATA_BLOCKS_DEF,
  parameter int LAST_POSITION = rsec_pkg::LAST_POSITION_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rsec_stream_if.sink                     in_chan,
  rsec_stream_if.source                   out_chan,
  input  logic                            cfg_we,
  input  logic [rsec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsec_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rsec_pkg::*;

  setup_t setup;
  coeff_t coeff;
  logic   q_valid, q_ready;
  work_t  q_word;

  rsec_setup #(.LAST_POSITION(LAST_POSITION)) u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .setup     (setup),
    .coeff     (coeff)
  );

  rsec_front #(.DATA_BLOCKS(DATA_BLOCKS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .setup   (setup),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_word  (q_word)
  );

  rsec_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_word   (q_word),
    .coeff    (coeff),
    .out_chan (out_chan)
  );

endmodule

### rtl/rsec_setup.sv
// ----------------------------------------------------------------------------
// rsec_setup
// Configuration registers and the sequencer that builds the coefficient
// matrix, the inverse of the Vandermonde matrix of the erasure locators.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsec_setup #(
  parameter int LAST_POSITION = rsec_pkg::LAST_POSITION_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rsec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsec_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output rsec_pkg::setup_t                 setup,
  output rsec_pkg::coeff_t                 coeff
);
  import rsec_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOC  = 3'd1;
  localparam logic [2:0] S_PROD = 3'd2;
  localparam logic [2:0] S_INV  = 3'd3;
  localparam logic [2:0] S_ROW  = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [2:0]      count_r;
  logic [3:0][6:0] pos_r;
  logic [3:0][7:0] loc_r;
  logic            ok_r;
  coeff_t          coeff_r;
  logic [1:0]      row_r, k_r;
  logic [3:0][7:0] poly_r;
  logic [7:0]      den_r, inv_r;

  logic            cfg_hit;
  logic            dup;
  logic [3:0][7:0] loc_nxt;
  logic [3:0][7:0] poly_step;
  logic            k_take;
  logic            row_act;
  logic            last_row;

  assign cfg_hit = cfg_we && (cfg_index <= CFG_POS3);

  // Locator exponent (LAST_POSITION - pos) mod 255 stays below twice the order.
  always_comb begin
    logic [8:0] e9;
    for (int i = 0; i < MAX_ERASURES; i++) begin
      e9 = 9'(LAST_POSITION) + 9'(GF_ORDER) - {2'b00, pos_r[i]};
      if (e9 >= 9'(GF_ORDER)) e9 = e9 - 9'(GF_ORDER);
      loc_nxt[i] = GF_EXP[e9[7:0]];
    end
  end

  // Two used positions that coincide make the matrix singular.
  always_comb begin
    dup = 1'b0;
    for (int i = 1; i < MAX_ERASURES; i++) begin
      for (int j = 0; j < i; j++) begin
        if ((3'(i) < count_r) && (pos_r[i] == pos_r[j])) dup = 1'b1;
      end
    end
  end

  // Multiply the running product by (z + X_k).
  always_comb begin
    poly_step[0] = gf_mul(loc_r[k_r], poly_r[0]);
    for (int m = 1; m < MAX_ERASURES; m++) begin
      poly_step[m] = gf_mul(loc_r[k_r], poly_r[m]) ^ poly_r[m-1];
    end
  end

  assign k_take   = ({1'b0, k_r} < count_r) && (k_r != row_r);
  assign row_act  = ({1'b0, row_r} < count_r);
  assign last_row = (state_r == S_ROW) && (row_r == 2'd3);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  state_nxt = S_IDLE;
      S_LOC:   state_nxt = S_PROD;
      S_PROD:  state_nxt = (k_r == 2'd3) ? S_INV : S_PROD;
      S_INV:   state_nxt = S_ROW;
      S_ROW:   state_nxt = (row_r == 2'd3) ? S_IDLE : S_PROD;
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_hit) state_nxt = S_LOC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pos_r   <= '0;
      ok_r    <= 1'b1;
      coeff_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_hit) begin
        if (cfg_index == CFG_COUNT) begin
          count_r <= cfg_wdata[2:0];
        end else begin
          pos_r[2'(cfg_index - CFG_POS0)] <= cfg_wdata;
        end
      end
      if (state_r == S_LOC) ok_r <= !dup;
      if (state_r == S_ROW) begin
        for (int j = 0; j < MAX_ERASURES; j++) begin
          coeff_r[row_r][j] <= row_act ? gf_mul(poly_r[j], inv_r) : 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_LOC: begin
        loc_r  <= loc_nxt;
        row_r  <= 2'd0;
        k_r    <= 2'd0;
        poly_r <= {8'd0, 8'd0, 8'd0, 8'd1};
        den_r  <= 8'd1;
      end
      S_PROD: begin
        if (k_take) begin
          poly_r <= poly_step;
          den_r  <= gf_mul(den_r, loc_r[row_r] ^ loc_r[k_r]);
        end
        k_r <= k_r + 2'd1;
      end
      S_INV: begin
        inv_r <= gf_inv(den_r);
      end
      S_ROW: begin
        row_r  <= row_r + 2'd1;
        k_r    <= 2'd0;
        poly_r <= {8'd0, 8'd0, 8'd0, 8'd1};
        den_r  <= 8'd1;
      end
      default: begin
      end
    endcase
  end

  assign setup.count = count_r;
  assign setup.pos   = pos_r;
  assign setup.ok    = ok_r;
  assign setup.busy  = (state_r != S_IDLE);
  assign coeff       = coeff_r;

  `RSEC_ASSERT_NEXT(a_cfg_starts_setup, cfg_hit, state_r == S_LOC, "setup did not restart")
  `RSEC_ASSERT_NOW(a_row_walk, last_row && !cfg_hit, state_nxt == S_IDLE, "setup overran")

endmodule

### rtl/rsec_front.sv
// ----------------------------------------------------------------------------
// rsec_front
// Accepts columns, classifies them (status, used lanes, write mask) and
// holds them in a short queue for the back part.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsec_front #(
  parameter int DATA_BLOCKS = rsec_pkg::DATA_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  rsec_stream_if.sink       in_chan,
  input  rsec_pkg::setup_t  setup,
  output logic              q_valid,
  input  logic              q_ready,
  output rsec_pkg::work_t   q_word
);
  import rsec_pkg::*;

  work_t      q_r [QUEUE_DEPTH];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  work_t      cls;

  always_comb begin
    cls.item   = in_chan.payload;
    cls.status = (setup.count > 3'(MAX_ERASURES)) || !setup.ok;
    for (int i = 0; i < MAX_ERASURES; i++) begin
      cls.used[i] = (3'(i) < setup.count);
      cls.mask[i] = cls.used[i] && !cls.status &&
                    ({1'b0, setup.pos[i]} < 8'(DATA_BLOCKS));
    end
  end

  assign in_chan.ready = (cnt_r != 2'(QUEUE_DEPTH)) && !setup.busy;
  assign push    = in_chan.valid && in_chan.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_word  = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wptr_r] <= cls;
  end

  `RSEC_ASSERT_NOW(a_no_overflow, cnt_r == 2'(QUEUE_DEPTH), !push, "queue overflow")

endmodule

### rtl/rsec_back.sv
// ----------------------------------------------------------------------------
// rsec_back
// Multiplies the syndromes by the coefficient matrix, corrects the erased
// bytes and holds the result in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsec_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  rsec_pkg::work_t  q_word,
  input  rsec_pkg::coeff_t coeff,
  rsec_stream_if.source    out_chan
);
  import rsec_pkg::*;

  logic            out_valid_r;
  out_item_t       out_r;
  out_item_t       res;
  logic [3:0][7:0] syn, dat, fix;
  logic            err_clean;

  assign syn = {q_word.item.syndrome_3, q_word.item.syndrome_2,
                q_word.item.syndrome_1, q_word.item.syndrome_0};
  assign dat = {q_word.item.data_3, q_word.item.data_2,
                q_word.item.data_1, q_word.item.data_0};

  always_comb begin
    logic [7:0] e;
    for (int i = 0; i < MAX_ERASURES; i++) begin
      e = '0;
      for (int j = 0; j < MAX_ERASURES; j++) e = e ^ gf_mul(coeff[i][j], syn[j]);
      fix[i] = (q_word.used[i] && !q_word.status) ? (dat[i] ^ e) : 8'd0;
    end
    res.fixed_0    = fix[0];
    res.fixed_1    = fix[1];
    res.fixed_2    = fix[2];
    res.fixed_3    = fix[3];
    res.write_mask = q_word.mask;
    res.status     = q_word.status;
    res.last_out   = q_word.item.column_last;
  end

  assign q_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_ready) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) out_r <= res;
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;

  assign err_clean = (out_r.write_mask == 4'd0) && (out_r.fixed_0 == 8'd0) &&
                     (out_r.fixed_1 == 8'd0) && (out_r.fixed_2 == 8'd0) &&
                     (out_r.fixed_3 == 8'd0);

  `RSEC_ASSERT_NOW(a_error_clean, out_valid_r && out_r.status, err_clean, "error not cleared")

endmodule
